@@ src/gbs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared types and constants for the greedy box suppression block.
// ----------------------------------------------------------------------------
package gbs_pkg;

    localparam int COORD_W  = 16;
    localparam int ID_W     = 16;
    localparam int LABEL_W  = 16;
    localparam int THR_W    = 17;
    localparam int FRAC_W   = 16;
    localparam logic [THR_W-1:0] THR_RESET = 17'd32768;

    // Stored box word: four coordinates, label, id
    localparam int BOX_W = 4 * COORD_W + LABEL_W + ID_W;

    // Derived arithmetic widths
    localparam int SPAN_W = COORD_W + 2;            // right - left + 1
    localparam int AREA_W = 2 * SPAN_W;             // product of two spans
    localparam int PROD_W = AREA_W + THR_W + 1;     // threshold times area

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // store the accepted box
        logic init_i;     // point the pick index at the newest box
        logic dec_i;      // step the pick index down
        logic rd_i;       // read box at pick index
        logic rd_j;       // read box at compare index
        logic lat_pick;   // latch the picked box and mark it
        logic emit;       // pass pending pick to output, hold new one
        logic inc_j;      // step the compare index up
        logic cmp1;       // spans and overlap extents
        logic cmp2;       // area and intersection products
        logic cmp3;       // threshold product
        logic cmp4;       // compare and suppress
        logic flush;      // send last pick, clear the set
    } gbs_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic flag_i;     // box at pick index already suppressed
        logic flag_j;     // box at compare index already suppressed
        logic i_zero;     // pick index at the first box
        logic j_at_i;     // compare index reached pick index
        logic out_free;   // output register can take a transaction
    } gbs_status_t;

endpackage

@@ src/gbs_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbs_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module gbs_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/gbs_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbs_ctrl
// Sequencer for loading boxes and running the greedy suppression passes.
// ----------------------------------------------------------------------------
module gbs_ctrl
    import gbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_last,
    output logic        in_stall,
    input  gbs_status_t status,
    output gbs_cmd_t    cmd
);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_START  = 12'b0000_0000_0010,
        S_SCAN_I = 12'b0000_0000_0100,
        S_LAT_I  = 12'b0000_0000_1000,
        S_EMIT   = 12'b0000_0001_0000,
        S_SCAN_J = 12'b0000_0010_0000,
        S_CMP1   = 12'b0000_0100_0000,
        S_CMP2   = 12'b0000_1000_0000,
        S_CMP3   = 12'b0001_0000_0000,
        S_CMP4   = 12'b0010_0000_0000,
        S_NEXT_I = 12'b0100_0000_0000,
        S_FLUSH  = 12'b1000_0000_0000
    } gbs_state_t;

    gbs_state_t state_reg, state_next;
    logic       accept;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    if (in_last)
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                cmd.init_i = 1'b1;
                state_next = S_SCAN_I;
            end
            S_SCAN_I:
            begin
                if (!status.flag_i)
                begin
                    cmd.rd_i   = 1'b1;
                    state_next = S_LAT_I;
                end
                else if (status.i_zero)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    cmd.dec_i = 1'b1;
                end
            end
            S_LAT_I:
            begin
                cmd.lat_pick = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_SCAN_J;
                end
            end
            S_SCAN_J:
            begin
                if (status.j_at_i)
                begin
                    state_next = S_NEXT_I;
                end
                else if (status.flag_j)
                begin
                    cmd.inc_j = 1'b1;
                end
                else
                begin
                    cmd.rd_j   = 1'b1;
                    state_next = S_CMP1;
                end
            end
            S_CMP1:
            begin
                cmd.cmp1   = 1'b1;
                state_next = S_CMP2;
            end
            S_CMP2:
            begin
                cmd.cmp2   = 1'b1;
                state_next = S_CMP3;
            end
            S_CMP3:
            begin
                cmd.cmp3   = 1'b1;
                state_next = S_CMP4;
            end
            S_CMP4:
            begin
                cmd.cmp4   = 1'b1;
                cmd.inc_j  = 1'b1;
                state_next = S_SCAN_J;
            end
            S_NEXT_I:
            begin
                if (status.i_zero)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    cmd.dec_i  = 1'b1;
                    state_next = S_SCAN_I;
                end
            end
            S_FLUSH:
            begin
                if (status.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // One state at a time
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("controller state not one-hot");

endmodule

@@ src/gbs_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbs_dpath
// Box store, suppression flags, overlap arithmetic and pick output register.
// ----------------------------------------------------------------------------
module gbs_dpath
    import gbs_pkg::*;
#(
    parameter int MAX_BOXES = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gbs_cmd_t             cmd,
    output gbs_status_t          status,
    input  logic [THR_W-1:0]     thr,
    input  logic [BOX_W-1:0]     in_word,
    input  logic                 out_stall,
    output logic                 out_valid,
    output logic [ID_W-1:0]      out_id,
    output logic                 out_last
);

    localparam int IW = $clog2(MAX_BOXES);
    localparam int CW = $clog2(MAX_BOXES + 1);

    logic [CW-1:0]        count_reg;
    logic [IW-1:0]        i_reg, j_reg;
    logic [MAX_BOXES-1:0] flags_reg;
    logic                 full;
    logic [IW-1:0]        raddr;
    logic [BOX_W-1:0]     rdata;

    // Picked box
    logic signed [COORD_W-1:0] pk_l_reg, pk_r_reg, pk_t_reg, pk_b_reg;
    logic [LABEL_W-1:0]        pk_label_reg;
    logic [ID_W-1:0]           pk_id_reg;

    // Pending pick and output register
    logic [ID_W-1:0] pend_id_reg;
    logic            pend_valid_reg;
    logic            out_valid_reg, out_last_reg;
    logic [ID_W-1:0] out_id_reg;
    logic            out_free;

    // Compare pipeline
    logic signed [COORD_W-1:0] e_l, e_r, e_t, e_b;
    logic [LABEL_W-1:0]        e_label;
    logic signed [SPAN_W-1:0]  aw_next, ah_next, w_next, h_next;
    logic signed [SPAN_W-1:0]  aw_reg, ah_reg, w_reg, h_reg;
    logic                      ok_reg;
    logic signed [AREA_W-1:0]  area_reg, inter_reg;
    logic signed [PROD_W-1:0]  rhs_reg, lhs_reg;
    logic                      ok2_reg, ok3_reg;
    logic                      hit;

    assign full     = (count_reg == CW'(MAX_BOXES));
    assign raddr    = cmd.rd_j ? j_reg : i_reg;
    assign out_free = !out_valid_reg || !out_stall;

    gbs_ram #(
        .WIDTH (BOX_W),
        .DEPTH (MAX_BOXES)
    ) u_store (
        .clk   (clk),
        .we    (cmd.load && !full),
        .waddr (count_reg[IW-1:0]),
        .wdata (in_word),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Unpack the box read back
    assign e_l     = $signed(rdata[COORD_W-1:0]);
    assign e_r     = $signed(rdata[2*COORD_W-1:COORD_W]);
    assign e_t     = $signed(rdata[3*COORD_W-1:2*COORD_W]);
    assign e_b     = $signed(rdata[4*COORD_W-1:3*COORD_W]);
    assign e_label = rdata[4*COORD_W+LABEL_W-1:4*COORD_W];

    // Spans of the earlier box and extents of the overlap
    always_comb
    begin
        aw_next = SPAN_W'(e_r) - SPAN_W'(e_l) + SPAN_W'(1);
        ah_next = SPAN_W'(e_b) - SPAN_W'(e_t) + SPAN_W'(1);
        w_next  = SPAN_W'((pk_r_reg < e_r) ? pk_r_reg : e_r)
                - SPAN_W'((pk_l_reg >= e_l) ? pk_l_reg : e_l) + SPAN_W'(1);
        h_next  = SPAN_W'((pk_b_reg < e_b) ? pk_b_reg : e_b)
                - SPAN_W'((pk_t_reg >= e_t) ? pk_t_reg : e_t) + SPAN_W'(1);
    end

    assign hit = ok3_reg && (lhs_reg >= rhs_reg);

    // Compare pipeline registers
    always_ff @(posedge clk)
    begin
        if (cmd.lat_pick)
        begin
            pk_l_reg     <= e_l;
            pk_r_reg     <= e_r;
            pk_t_reg     <= e_t;
            pk_b_reg     <= e_b;
            pk_label_reg <= e_label;
            pk_id_reg    <= rdata[BOX_W-1:BOX_W-ID_W];
        end
        if (cmd.cmp1)
        begin
            aw_reg <= aw_next;
            ah_reg <= ah_next;
            w_reg  <= w_next;
            h_reg  <= h_next;
            ok_reg <= (e_label == pk_label_reg) && (w_next > 0) && (h_next > 0);
        end
        if (cmd.cmp2)
        begin
            area_reg  <= AREA_W'(aw_reg * ah_reg);
            inter_reg <= AREA_W'(w_reg * h_reg);
            ok2_reg   <= ok_reg;
        end
        if (cmd.cmp3)
        begin
            rhs_reg <= PROD_W'($signed({1'b0, thr}) * area_reg);
            lhs_reg <= PROD_W'(inter_reg) <<< FRAC_W;
            ok3_reg <= ok2_reg;
        end
        if (cmd.emit)
        begin
            pend_id_reg <= pk_id_reg;
        end
    end

    // Count, indexes, flags, pending pick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            flags_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load && !full)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.init_i)
            begin
                i_reg <= IW'(count_reg - CW'(1));
            end
            if (cmd.dec_i)
            begin
                i_reg <= i_reg - IW'(1);
            end
            if (cmd.emit)
            begin
                j_reg          <= '0;
                pend_valid_reg <= 1'b1;
            end
            if (cmd.inc_j)
            begin
                j_reg <= j_reg + IW'(1);
            end
            if (cmd.lat_pick)
            begin
                flags_reg[i_reg] <= 1'b1;
            end
            if (cmd.cmp4 && hit)
            begin
                flags_reg[j_reg] <= 1'b1;
            end
            if (cmd.flush)
            begin
                count_reg      <= '0;
                flags_reg      <= '0;
                pend_valid_reg <= 1'b0;
            end
        end
    end

    // Output register: drop on take, load on emit of a pending pick or on flush
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((cmd.emit && pend_valid_reg) || cmd.flush)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((cmd.emit && pend_valid_reg) || cmd.flush)
        begin
            out_id_reg   <= pend_id_reg;
            out_last_reg <= cmd.flush;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_id    = out_id_reg;
    assign out_last  = out_last_reg;

    assign status.flag_i   = flags_reg[i_reg];
    assign status.flag_j   = flags_reg[j_reg];
    assign status.i_zero   = (i_reg == '0);
    assign status.j_at_i   = (j_reg == i_reg);
    assign status.out_free = out_free;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_BOXES))
        else $error("box count beyond store depth");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit || cmd.flush) |-> out_free)
        else $error("pick issued over a held transaction");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |=> (count_reg == '0) && (flags_reg == '0) && !pend_valid_reg)
        else $error("set not cleared after flush");

    a_flush_pending: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |-> pend_valid_reg)
        else $error("final pick without a pending box");

endmodule

@@ src/greedy_box_suppression.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_box_suppression
// Greedy suppression of overlapping labelled boxes, one pick per transaction.
// ----------------------------------------------------------------------------
// Boxes come in ascending score order, one per cycle while the block is idle,
// into a RAM of MAX_BOXES entries; boxes past that depth are dropped. The box
// with last_box set starts the run, which walks from the newest box to the
// oldest. Each unsuppressed box is picked and then compared against every
// earlier unsuppressed box; a compare goes through one registered RAM read and
// four arithmetic steps, and a skipped box is passed over without a compare.
// The run uses that one shared compare unit; input stays stalled meanwhile.
// Each pick leaves through an output register; last_pick marks the final one.
module greedy_box_suppression
    import gbs_pkg::*;
#(
    parameter int MAX_BOXES = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [THR_W-1:0]          cfg_wr_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [ID_W-1:0]           box_id,
    input  logic signed [COORD_W-1:0] x_left,
    input  logic signed [COORD_W-1:0] x_right,
    input  logic signed [COORD_W-1:0] y_top,
    input  logic signed [COORD_W-1:0] y_bottom,
    input  logic [LABEL_W-1:0]        class_label,
    input  logic                      last_box,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [ID_W-1:0]           picked_id,
    output logic                      last_pick
);

    logic [THR_W-1:0] thr_reg;
    gbs_cmd_t         cmd;
    gbs_status_t      status;
    logic [BOX_W-1:0] in_word;

    // Threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_wr_en)
        begin
            thr_reg <= cfg_wr_data;
        end
    end

    assign in_word = {box_id, class_label, y_bottom, y_top, x_right, x_left};

    gbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_last  (last_box),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    gbs_dpath #(
        .MAX_BOXES (MAX_BOXES)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .thr       (thr_reg),
        .in_word   (in_word),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_id    (picked_id),
        .out_last  (last_pick)
    );

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for greedy_box_suppression: box sets go in through the
// valid/stall input channel, and each picked id that comes out is compared
// with a local greedy suppression predictor over several threshold settings.
// ----------------------------------------------------------------------------
module tb;
    import gbs_pkg::*;

    localparam int NBOX = 64;

    typedef struct {
        logic [ID_W-1:0]           id;
        logic signed [COORD_W-1:0] xl;
        logic signed [COORD_W-1:0] xr;
        logic signed [COORD_W-1:0] yt;
        logic signed [COORD_W-1:0] yb;
        logic [LABEL_W-1:0]        lab;
        logic                      last;
        logic                      has_exp;
        logic [ID_W-1:0]           exp_id;
    } box_row_t;

    typedef struct {
        logic [ID_W-1:0] id;
        logic            last;
    } pick_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_wr_en;
    logic [THR_W-1:0]          cfg_wr_data;
    logic                      in_valid;
    logic                      in_stall;
    logic [ID_W-1:0]           box_id;
    logic signed [COORD_W-1:0] x_left;
    logic signed [COORD_W-1:0] x_right;
    logic signed [COORD_W-1:0] y_top;
    logic signed [COORD_W-1:0] y_bottom;
    logic [LABEL_W-1:0]        class_label;
    logic                      last_box;
    logic                      out_valid;
    logic                      out_stall;
    logic [ID_W-1:0]           picked_id;
    logic                      last_pick;

    // typed expectation travels with the payload
    logic                      row_has_exp;
    logic [ID_W-1:0]           row_exp_id;

    box_row_t   set_store [NBOX];
    bit         supp_flag [NBOX];
    int         set_count;
    longint     thr_model;
    pick_t      pick_q [$];
    int         mismatches;
    int         tx_gap_pct;
    int         rx_stall_pct;
    int         items_sent;
    box_row_t   directed [14];

    greedy_box_suppression #(.MAX_BOXES(NBOX)) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .box_id      (box_id),
        .x_left      (x_left),
        .x_right     (x_right),
        .y_top       (y_top),
        .y_bottom    (y_bottom),
        .class_label (class_label),
        .last_box    (last_box),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .picked_id   (picked_id),
        .last_pick   (last_pick)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    task automatic report_mismatch(input string msg);
    begin
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatches++;
    end
    endtask

    // Decide whether the picked box k knocks out the earlier box e
    function automatic bit overlaps_enough(input int k, input int e);
        longint aw;
        longint ah;
        longint w;
        longint h;
        longint lo;
        longint hi;
    begin
        if (set_store[k].lab != set_store[e].lab)
            return 0;
        aw = longint'(set_store[e].xr) - longint'(set_store[e].xl) + 1;
        ah = longint'(set_store[e].yb) - longint'(set_store[e].yt) + 1;
        hi = (set_store[k].xr < set_store[e].xr) ? set_store[k].xr : set_store[e].xr;
        lo = (set_store[k].xl >= set_store[e].xl) ? set_store[k].xl : set_store[e].xl;
        w  = hi - lo + 1;
        hi = (set_store[k].yb < set_store[e].yb) ? set_store[k].yb : set_store[e].yb;
        lo = (set_store[k].yt >= set_store[e].yt) ? set_store[k].yt : set_store[e].yt;
        h  = hi - lo + 1;
        if (w <= 0 || h <= 0)
            return 0;
        return (w * h * 65536) >= (thr_model * aw * ah);
    end
    endfunction

    // Load one box and, on the closing box, run greedy suppression
    task automatic predict_picks(input box_row_t b);
        pick_t p;
        int    first;
    begin
        if (set_count < NBOX)
        begin
            set_store[set_count] = b;
            supp_flag[set_count] = 0;
            set_count++;
        end
        if (b.last)
        begin
            first = pick_q.size();
            for (int i = set_count - 1; i >= 0; i--)
            begin
                if (!supp_flag[i])
                begin
                    supp_flag[i] = 1;
                    p.id   = set_store[i].id;
                    p.last = 1'b0;
                    pick_q.push_back(p);
                    for (int j = 0; j < i; j++)
                        if (!supp_flag[j] && overlaps_enough(i, j))
                            supp_flag[j] = 1;
                end
            end
            if (pick_q.size() > first)
                pick_q[pick_q.size() - 1].last = 1'b1;
            if (b.has_exp)
            begin
                while (pick_q.size() > first)
                    void'(pick_q.pop_back());
                p.id   = b.exp_id;
                p.last = 1'b1;
                pick_q.push_back(p);
            end
            for (int i = 0; i < NBOX; i++)
                supp_flag[i] = 0;
            set_count = 0;
        end
    end
    endtask

    // Predict on every accepted input transaction
    always @(posedge clk)
    begin
        box_row_t b;
        if (rst_n && in_valid && !in_stall)
        begin
            b.id = box_id;      b.xl = x_left;   b.xr = x_right;
            b.yt = y_top;       b.yb = y_bottom; b.lab = class_label;
            b.last = last_box;  b.has_exp = row_has_exp;
            b.exp_id = row_exp_id;
            predict_picks(b);
        end
    end

    // Check every accepted output transaction against the oldest expectation
    always @(posedge clk)
    begin
        pick_t p;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pick_q.size() == 0)
                report_mismatch($sformatf("unexpected pick id=%h", picked_id));
            else
            begin
                p = pick_q.pop_front();
                if (picked_id !== p.id)
                    report_mismatch($sformatf("picked_id %h, want %h", picked_id, p.id));
                if (last_pick !== p.last)
                    report_mismatch($sformatf("last_pick %b, want %b", last_pick, p.last));
            end
        end
    end

    // Random receiver stall
    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < rx_stall_pct);

    task automatic send_box(input box_row_t b);
    begin
        if ($urandom_range(0, 99) < tx_gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        box_id <= b.id;     x_left <= b.xl;      x_right <= b.xr;
        y_top <= b.yt;      y_bottom <= b.yb;    class_label <= b.lab;
        last_box <= b.last; row_has_exp <= b.has_exp; row_exp_id <= b.exp_id;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        // three idling regimes across the run
        if (items_sent < 45)
        begin
            tx_gap_pct = 8;  rx_stall_pct = 45;
        end
        else if (items_sent < 90)
        begin
            tx_gap_pct = 45; rx_stall_pct = 8;
        end
        else
        begin
            tx_gap_pct = 0;  rx_stall_pct = 0;
        end
    end
    endtask

    // Hold input until every expected pick is out, then let the flush settle
    task automatic drain_picks();
    begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pick_q.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    end
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] v);
    begin
        drain_picks();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        thr_model = longint'(v);
    end
    endtask

    function automatic box_row_t rand_box(input bit last);
        box_row_t b;
        int       sel;
        int       cx;
        int       cy;
    begin
        sel = $urandom_range(0, 99);
        b.id = ID_W'($urandom);
        b.lab = (sel % 10 < 7) ? LABEL_W'($urandom_range(0, 1)) : LABEL_W'($urandom);
        if (sel < 12)
        begin
            // full-range coordinates, possibly malformed
            b.xl = COORD_W'($urandom); b.xr = COORD_W'($urandom);
            b.yt = COORD_W'($urandom); b.yb = COORD_W'($urandom);
        end
        else
        begin
            cx = $urandom_range(0, 40) - 20;
            cy = $urandom_range(0, 40) - 20;
            b.xl = COORD_W'(cx);
            b.yt = COORD_W'(cy);
            b.xr = COORD_W'(cx + int'($urandom_range(0, 15)));
            b.yb = COORD_W'(cy + int'($urandom_range(0, 15)));
            if (sel > 94)
                b.xr = COORD_W'(cx - int'($urandom_range(1, 3)));
        end
        b.last = last;
        b.has_exp = 1'b0;
        b.exp_id = '0;
        return b;
    end
    endfunction

    task automatic send_random_set(input int n);
    begin
        for (int k = 0; k < n; k++)
            send_box(rand_box(k == n - 1));
    end
    endtask

    // Watchdog
    initial
    begin
        #(12 * 3000000);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        logic [THR_W-1:0] thr_list [5];
        rst_n = 1'b0;
        cfg_wr_en <= 1'b0;   cfg_wr_data <= '0;
        in_valid <= 1'b0;    out_stall <= 1'b0;
        box_id <= '0;        x_left <= '0;     x_right <= '0;
        y_top <= '0;         y_bottom <= '0;   class_label <= '0;
        last_box <= 1'b0;    row_has_exp <= 1'b0; row_exp_id <= '0;
        set_count = 0;       thr_model = THR_RESET;
        mismatches = 0;      items_sent = 0;
        tx_gap_pct = 8;      rx_stall_pct = 45;
        for (int i = 0; i < NBOX; i++)
            supp_flag[i] = 0;

        // id, left, right, top, bottom, label, last, typed, expected id
        directed[0]  = '{16'hFFFF, -32768, 32767, -32768, 32767, 16'hFFFF, 1, 1, 16'hFFFF};
        directed[1]  = '{16'h0000, 0, 0, 0, 0, 16'h0000, 1, 1, 16'h0000};
        // identical boxes, same label: only the newer survives
        directed[2]  = '{16'h0001, 0, 9, 0, 9, 16'h0005, 0, 0, 0};
        directed[3]  = '{16'h0002, 0, 9, 0, 9, 16'h0005, 1, 1, 16'h0002};
        // disjoint boxes
        directed[4]  = '{16'h0003, 0, 4, 0, 4, 16'h0001, 0, 0, 0};
        directed[5]  = '{16'h0004, 10, 14, 10, 14, 16'h0001, 1, 0, 0};
        // same box, different labels
        directed[6]  = '{16'h0005, 0, 9, 0, 9, 16'h0001, 0, 0, 0};
        directed[7]  = '{16'h0006, 0, 9, 0, 9, 16'h0002, 1, 0, 0};
        // malformed earlier box, zero-width earlier box, partial overlap
        directed[8]  = '{16'h0007, 5, 2, 0, 9, 16'h0003, 0, 0, 0};
        directed[9]  = '{16'h0008, 4, 3, 0, 9, 16'h0003, 0, 0, 0};
        directed[10] = '{16'h0009, 0, 9, 0, 9, 16'h0003, 0, 0, 0};
        directed[11] = '{16'h000A, 5, 14, 0, 9, 16'h0003, 0, 0, 0};
        directed[12] = '{16'h000B, -32768, -32768, 32767, 32767, 16'h0003, 0, 0, 0};
        directed[13] = '{16'h000C, 0, 9, 0, 9, 16'h0003, 1, 0, 0};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table under the reset threshold
        foreach (directed[r])
            send_box(directed[r]);
        drain_picks();

        // Full store plus dropped boxes, last one closes the set
        send_random_set(NBOX + 2);

        thr_list = '{17'd0, 17'd65536, 17'h1FFFF, 17'd32768, 17'($urandom_range(1, 65535))};
        foreach (thr_list[t])
        begin
            write_threshold(thr_list[t]);
            for (int s = 0; s < 3; s++)
                send_random_set($urandom_range(1, 6));
        end

        drain_picks();
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
